[hw/rtl/drbu_pkg.sv]
// Shared types and constants of the raw bank unpacker.
package drbu_pkg;

   // Cell map sizing; the map index is the cell id modulo CELL_COUNT.
   localparam int CELL_COUNT = 2048;
   localparam int CELL_IDX_W = $clog2(CELL_COUNT);

   // Field widths of the bank format and the results.
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 7;
   localparam int CRATE_W = 5;
   localparam int CHAN_W  = 6;
   localparam int CELL_W  = CRATE_W + CHAN_W;
   localparam int VALUE_W = 10;

   // Card header layout.
   localparam int HDR_TRIG_LSB  = 0;
   localparam int HDR_ADC_LSB   = 7;
   localparam int HDR_CRATE_LSB = 18;
   localparam int HDR_GEN_BIT   = 23;
   localparam int HDR_SYNC_BIT  = 28;
   localparam int HDR_LINK_BIT  = 29;

   // Entry layouts.
   localparam int TRIG_HIT_BIT  = 6;
   localparam int ADC_CHAN_LSB  = 10;

   // Seen memory: one tag per cell and digit kind.
   localparam int MEM_ADDR_W = CELL_IDX_W + 1;
   localparam int MEM_DEPTH  = 2 * CELL_COUNT;
   localparam int EPOCH_W    = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_TRIG   = 2'd1,
      KIND_ADC    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_TRIG   = 2'd1,
      PHASE_ADC    = 2'd2
   } phase_type;

   typedef enum logic {
      REG_SKIP_TRIG = 1'b0,
      REG_SKIP_ADC  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic skip_trigger;
      logic skip_adc;
   } cfg_type;

   // One operation of the map stage: a result to emit, or a bare event marker.
   typedef struct packed {
      logic              emit;
      logic              check;
      logic              bump;
      kind_type          kind;
      logic [CELL_W-1:0] cell_id;
      logic [VALUE_W-1:0] value;
      logic              general_error;
      logic              sync_error;
      logic              link_error;
      logic              truncated;
      logic              last;
   } op_type;

   typedef struct packed {
      kind_type           kind;
      logic [CELL_W-1:0]  cell_id;
      logic [VALUE_W-1:0] value;
      logic               general_error;
      logic               sync_error;
      logic               link_error;
      logic               duplicate;
      logic               truncated;
      logic               last;
   } rsp_type;

endpackage

[hw/rtl/drbu_req_if.sv]
// Input channel: one bank word per item.
interface drbu_req_if
   import drbu_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] bank_word;
   logic              first_of_event;
   logic              last_of_bank;

   modport source (output valid, bank_word, first_of_event, last_of_bank, input ready);
   modport sink   (input valid, bank_word, first_of_event, last_of_bank, output ready);
endinterface

[hw/rtl/drbu_rsp_if.sv]
// Result channel: one header or digit per item.
interface drbu_rsp_if
   import drbu_pkg::*;
   ();
   logic               valid;
   logic               ready;
   kind_type           kind;
   logic [CELL_W-1:0]  cell_id;
   logic [VALUE_W-1:0] value;
   logic               general_error;
   logic               sync_error;
   logic               link_error;
   logic               duplicate;
   logic               truncated;
   logic               last;

   modport source (output valid, kind, cell_id, value, general_error, sync_error,
                   link_error, duplicate, truncated, last, input ready);
   modport sink   (input valid, kind, cell_id, value, general_error, sync_error,
                   link_error, duplicate, truncated, last, output ready);
endinterface

[hw/rtl/detector_raw_bank_unpacker.sv]
// Top level of the raw bank unpacker: parser, duplicate check and registers.
//
// The req channel takes one 32-bit bank word per item, with first_of_event and
// last_of_bank. The rsp channel gives one item per header or digit: a header
// word yields one item, a trigger word up to four digits, an ADC word up to two.
// Skipped words yield nothing, or a header when they cut the bank short; the last
// result of a word carries last. Items move on valid and ready high at a rising edge.
//
// The parser holds a word in its slot and issues one operation per result, at
// least one, so up to four for a trigger word; it takes the next word when the
// last operation is taken. The seen memory is read once per operation and
// written once per digit. A result passes the slot, check and output registers.
//
// Reset is synchronous. After reset the seen memory is cleared, one entry a cycle;
// meanwhile the parser takes at most one word and holds it. The memory keeps an
// 8-bit event tag per cell and kind; when the tag runs out, the event start
// waits for another clearing pass. Configuration is taken over APB at any time
// and applies to words accepted after the write.
// When rsp stalls, the output register holds its item and the check stage and
// the input back up behind it; nothing is lost.
module detector_raw_bank_unpacker
   import drbu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   drbu_req_if.sink              req,
   drbu_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   logic    op_valid;
   logic    op_ready;
   op_type  op;

   // Register port.
   drbu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Word parser.
   drbu_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .cfg      (cfg),
      .op_valid (op_valid),
      .op_ready (op_ready),
      .op       (op)
   );

   // Duplicate check and output.
   drbu_seen u_seen (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_ready (op_ready),
      .op       (op),
      .rsp      (rsp)
   );

endmodule

[hw/rtl/drbu_csr.sv]
// Configuration registers behind the APB-style port.
module drbu_csr
   import drbu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          wr_en;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[2]);
   assign wr_en     = psel && penable && pwrite;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_SKIP_TRIG: cfg_in.skip_trigger = pwdata[0];
            REG_SKIP_ADC:  cfg_in.skip_adc     = pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      prdata = '0;
      unique case (reg_index)
         REG_SKIP_TRIG: prdata[0] = cfg_ff.skip_trigger;
         REG_SKIP_ADC:  prdata[0] = cfg_ff.skip_adc;
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/drbu_parser.sv]
// Bank parser: tracks the header phase and counts, and splits each word into operations.
module drbu_parser
   import drbu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   drbu_req_if.sink   req,
   input  cfg_type    cfg,
   output logic       op_valid,
   input  logic       op_ready,
   output op_type     op
);

   // Parse state, updated when a word is accepted.
   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] trig_left_ff, trig_left_in;
   logic [COUNT_W-1:0] adc_left_ff, adc_left_in;
   logic [CRATE_W-1:0] crate_ff, crate_in;

   // Holding slot for the word whose operations are being issued.
   logic               slot_valid_ff;
   logic [WORD_W-1:0]  slot_word_ff;
   kind_type           slot_kind_ff;
   logic [CRATE_W-1:0] slot_crate_ff;
   logic               slot_gen_ff, slot_sync_ff, slot_link_ff;
   logic               slot_trunc_ff;
   logic               slot_first_ff;
   logic               slot_emit_ff;
   logic [1:0]         slot_last_idx_ff;
   logic [1:0]         idx_ff;

   // Decode of the incoming word.
   logic [2:0]         n_res;
   logic [2:0]         take;
   kind_type           dec_kind;
   logic               dec_gen, dec_sync, dec_link;
   logic               dec_trunc;
   logic [1:0]         dec_last_idx;

   logic               req_fire;
   logic               op_fire;
   logic               op_final;
   logic [7:0]         trig_byte;
   logic [15:0]        adc_half;

   assign req_fire = req.valid && req.ready;
   assign op_fire  = op_valid && op_ready;
   assign op_final = (idx_ff == slot_last_idx_ff);
   assign req.ready = !slot_valid_ff || (op_ready && op_final);

   // Next parse state and the number of results of the incoming word.
   always_comb begin
      phase_in     = phase_ff;
      trig_left_in = trig_left_ff;
      adc_left_in  = adc_left_ff;
      crate_in     = crate_ff;
      n_res        = 3'd0;
      take         = 3'd0;
      dec_kind     = KIND_HEADER;
      dec_gen      = 1'b0;
      dec_sync     = 1'b0;
      dec_link     = 1'b0;
      unique case (phase_ff)
         PHASE_HEADER: begin
            trig_left_in = req.bank_word[HDR_TRIG_LSB +: COUNT_W];
            adc_left_in  = req.bank_word[HDR_ADC_LSB +: COUNT_W];
            crate_in     = req.bank_word[HDR_CRATE_LSB +: CRATE_W];
            dec_gen      = req.bank_word[HDR_GEN_BIT];
            dec_sync     = req.bank_word[HDR_SYNC_BIT];
            dec_link     = req.bank_word[HDR_LINK_BIT];
            n_res        = 3'd1;
            if (trig_left_in != '0) begin
               phase_in = PHASE_TRIG;
            end else if (adc_left_in != '0) begin
               phase_in = PHASE_ADC;
            end else begin
               phase_in = PHASE_HEADER;
            end
         end
         PHASE_TRIG: begin
            dec_kind     = KIND_TRIG;
            take         = (trig_left_ff < COUNT_W'(4)) ? trig_left_ff[2:0] : 3'd4;
            trig_left_in = trig_left_ff - COUNT_W'(take);
            n_res        = cfg.skip_trigger ? 3'd0 : take;
            if (trig_left_in == '0) begin
               phase_in = (adc_left_ff != '0) ? PHASE_ADC : PHASE_HEADER;
            end
         end
         PHASE_ADC: begin
            dec_kind    = KIND_ADC;
            take        = (adc_left_ff < COUNT_W'(2)) ? adc_left_ff[2:0] : 3'd2;
            adc_left_in = adc_left_ff - COUNT_W'(take);
            n_res       = cfg.skip_adc ? 3'd0 : take;
            if (adc_left_in == '0) begin
               phase_in = PHASE_HEADER;
            end
         end
         default: begin
            phase_in = PHASE_HEADER;
         end
      endcase

      // End of bank: flag a bank cut short and go back to the header phase.
      dec_trunc = req.last_of_bank && (phase_in != PHASE_HEADER);
      if (req.last_of_bank) begin
         if (n_res == 3'd0 && dec_trunc) begin
            n_res    = 3'd1;
            dec_kind = KIND_HEADER;
         end
         phase_in     = PHASE_HEADER;
         trig_left_in = '0;
         adc_left_in  = '0;
      end
      dec_last_idx = (n_res == 3'd0) ? 2'd0 : 2'(n_res - 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_HEADER;
         trig_left_ff <= '0;
         adc_left_ff  <= '0;
         crate_ff     <= '0;
      end else if (req_fire) begin
         phase_ff     <= phase_in;
         trig_left_ff <= trig_left_in;
         adc_left_ff  <= adc_left_in;
         crate_ff     <= crate_in;
      end
   end

   // Slot control.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         if (req_fire) begin
            slot_valid_ff <= 1'b1;
         end else if (op_fire && op_final) begin
            slot_valid_ff <= 1'b0;
         end
         if (req_fire || (op_fire && op_final)) begin
            idx_ff <= '0;
         end else if (op_fire) begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   // Slot payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         slot_word_ff     <= req.bank_word;
         slot_kind_ff     <= dec_kind;
         slot_crate_ff    <= crate_in;
         slot_gen_ff      <= dec_gen;
         slot_sync_ff     <= dec_sync;
         slot_link_ff     <= dec_link;
         slot_trunc_ff    <= dec_trunc;
         slot_first_ff    <= req.first_of_event;
         slot_emit_ff     <= (n_res != 3'd0);
         slot_last_idx_ff <= dec_last_idx;
      end
   end

   // Operation for the current entry slot.
   assign trig_byte = slot_word_ff[{idx_ff, 3'b000} +: 8];
   assign adc_half  = slot_word_ff[{idx_ff[0], 4'b0000} +: 16];

   always_comb begin
      op.emit          = slot_emit_ff;
      op.check         = slot_emit_ff && (slot_kind_ff != KIND_HEADER);
      op.bump          = slot_first_ff && (idx_ff == 2'd0);
      op.kind          = slot_kind_ff;
      op.general_error = slot_gen_ff;
      op.sync_error    = slot_sync_ff;
      op.link_error    = slot_link_ff;
      op.truncated     = slot_trunc_ff;
      op.last          = op_final;
      case (slot_kind_ff)
         KIND_TRIG: begin
            op.cell_id = {slot_crate_ff, trig_byte[CHAN_W-1:0]};
            op.value   = VALUE_W'(trig_byte[TRIG_HIT_BIT]);
         end
         KIND_ADC: begin
            op.cell_id = {slot_crate_ff, adc_half[ADC_CHAN_LSB +: CHAN_W]};
            op.value   = adc_half[VALUE_W-1:0];
         end
         default: begin
            op.cell_id = {slot_crate_ff, {CHAN_W{1'b0}}};
            op.value   = '0;
         end
      endcase
   end

   assign op_valid = slot_valid_ff;

endmodule

[hw/rtl/drbu_seen.sv]
// Duplicate check: epoch-tagged seen memory with read-modify-write and the output register.
module drbu_seen
   import drbu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       op_valid,
   output logic       op_ready,
   input  op_type     op,
   drbu_rsp_if.source rsp
);

   // Seen memory: each entry holds the epoch in which the cell was last seen.
   logic [EPOCH_W-1:0]    seen_mem [MEM_DEPTH];
   logic [EPOCH_W-1:0]    rd_data_ff;

   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic                  clear_busy_ff;
   logic [MEM_ADDR_W-1:0] clear_addr_ff;

   // Check stage.
   logic                  b_valid_ff;
   op_type                b_op_ff;
   logic                  fwd_valid_ff;
   logic [MEM_ADDR_W-1:0] fwd_addr_ff;

   // Output register.
   logic                  out_valid_ff;
   rsp_type               out_ff;

   logic                  op_fire;
   logic                  b_adv;
   logic                  out_free;
   logic                  wrap_pending;
   logic                  clear_start;
   logic                  clear_last;
   logic [MEM_ADDR_W-1:0] rd_addr;
   logic [MEM_ADDR_W-1:0] b_addr;
   logic [EPOCH_W-1:0]    cur_epoch;
   logic                  seen;
   logic                  mem_we;
   logic [MEM_ADDR_W-1:0] mem_waddr;
   logic [EPOCH_W-1:0]    mem_wdata;

   assign out_free     = !out_valid_ff || rsp.ready;
   assign b_adv        = b_valid_ff && (!b_op_ff.emit || out_free);
   assign wrap_pending = op.bump && (epoch_ff == EPOCH_MAX);
   assign op_ready     = !clear_busy_ff && !wrap_pending && (!b_valid_ff || b_adv);
   assign op_fire      = op_valid && op_ready;
   assign clear_start  = op_valid && wrap_pending && !b_valid_ff && !clear_busy_ff;
   assign clear_last   = (clear_addr_ff == MEM_ADDR_W'(MEM_DEPTH - 1));

   // Map address: digit kind selects the map, the cell id is taken modulo the map size.
   assign rd_addr = {op.kind == KIND_ADC, op.cell_id[CELL_IDX_W-1:0]};
   assign b_addr  = {b_op_ff.kind == KIND_ADC, b_op_ff.cell_id[CELL_IDX_W-1:0]};

   // A new event gets the next epoch; the previous write only counts within the same event.
   assign cur_epoch = b_op_ff.bump ? (epoch_ff + EPOCH_W'(1)) : epoch_ff;
   assign seen = (!b_op_ff.bump && fwd_valid_ff && (fwd_addr_ff == b_addr)) ||
                 (rd_data_ff == cur_epoch);

   // Write port: the clearing pass or the tag update of the checked digit.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = b_addr;
      mem_wdata = cur_epoch;
      if (clear_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_addr_ff;
         mem_wdata = EPOCH_NONE;
      end else if (b_adv && b_op_ff.check) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seen_mem[mem_waddr] <= mem_wdata;
      end
      if (op_fire) begin
         rd_data_ff <= seen_mem[rd_addr];
      end
   end

   // Epoch and clearing pass.
   always_comb begin
      epoch_in = epoch_ff;
      if (clear_start) begin
         epoch_in = EPOCH_FIRST;
      end else if (b_adv && b_op_ff.bump) begin
         epoch_in = cur_epoch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff      <= EPOCH_FIRST;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         epoch_ff <= epoch_in;
         if (clear_start) begin
            clear_busy_ff <= 1'b1;
            clear_addr_ff <= '0;
         end else if (clear_busy_ff) begin
            clear_busy_ff <= !clear_last;
            clear_addr_ff <= clear_addr_ff + MEM_ADDR_W'(1);
         end
      end
   end

   // Check stage and forwarding of the most recent tag write.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (op_fire) begin
            b_valid_ff <= 1'b1;
         end else if (b_adv) begin
            b_valid_ff <= 1'b0;
         end
         if (clear_busy_ff) begin
            fwd_valid_ff <= 1'b0;
         end else if (b_adv && b_op_ff.check) begin
            fwd_valid_ff <= 1'b1;
         end else if (b_adv && b_op_ff.bump) begin
            fwd_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_fire) begin
         b_op_ff <= op;
      end
      if (b_adv && b_op_ff.check) begin
         fwd_addr_ff <= b_addr;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (b_adv && b_op_ff.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv && b_op_ff.emit) begin
         out_ff.kind          <= b_op_ff.kind;
         out_ff.cell_id       <= b_op_ff.cell_id;
         out_ff.value         <= b_op_ff.value;
         out_ff.general_error <= b_op_ff.general_error;
         out_ff.sync_error    <= b_op_ff.sync_error;
         out_ff.link_error    <= b_op_ff.link_error;
         out_ff.duplicate     <= b_op_ff.check && seen;
         out_ff.truncated     <= b_op_ff.truncated;
         out_ff.last          <= b_op_ff.last;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.kind          = out_ff.kind;
   assign rsp.cell_id       = out_ff.cell_id;
   assign rsp.value         = out_ff.value;
   assign rsp.general_error = out_ff.general_error;
   assign rsp.sync_error    = out_ff.sync_error;
   assign rsp.link_error    = out_ff.link_error;
   assign rsp.duplicate     = out_ff.duplicate;
   assign rsp.truncated     = out_ff.truncated;
   assign rsp.last          = out_ff.last;

   // No operation may enter while the memory is being cleared.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !op_ready)
      else $error("operation accepted during clearing pass");

   // A wrap clear starts only with the check stage drained, so no stale tag lands after it.
   a_clear_drained: assert property (@(posedge clock) disable iff (reset)
      clear_start |-> !b_valid_ff)
      else $error("clearing pass started with a digit in flight");

   // A seen tag is never the reserved never-seen code.
   a_tag_nonzero: assert property (@(posedge clock) disable iff (reset)
      (b_adv && b_op_ff.check) |-> (cur_epoch != EPOCH_NONE))
      else $error("seen tag written with the empty code");

   // The first result of an event, the one that starts its epoch, is never a duplicate.
   a_bump_fresh: assert property (@(posedge clock) disable iff (reset)
      (b_adv && b_op_ff.bump && b_op_ff.emit) |=> !out_ff.duplicate)
      else $error("duplicate flagged on the first digit of an event");

endmodule
